### hdl/bma_pkg.sv
// ----------------------------------------------------------------------------
// Behavior motor arbiter package
// Sizes, configuration register indexes, sequencer states and the sign
// helpers shared by the arbiter.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int VEL_W      = 16;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int IN_SLOT_W  = 3;
    localparam int LIST_LEN   = 8;
    localparam int ENTRY_W    = 3;
    localparam int LIST_W     = LIST_LEN * ENTRY_W;
    localparam int LIST_IDX_W = $clog2(LIST_LEN);
    localparam int CNT_W      = $clog2(LIST_LEN + 1);
    localparam int GAIN_W     = 8;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 24;
    localparam int DIFF_W     = VEL_W + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int REC_W      = 2 * VEL_W + 1;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(16);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_MODE = 2'd0,
        CFG_PRIORITY   = 2'd1,
        CFG_GAIN       = 2'd2,
        CFG_LIMIT      = 2'd3
    } t_cfg_index;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_LOAD  = 7'b0001000,
        ST_GUARD = 7'b0010000,
        ST_PROD  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    typedef logic signed [1:0]       t_sign;
    typedef logic signed [VEL_W-1:0] t_vel;

    function automatic t_sign sign_of(input t_vel v);
        t_sign s;
        if (v == '0) begin
            s = 2'sd0;
        end else if (v[VEL_W-1]) begin
            s = -2'sd1;
        end else begin
            s = 2'sd1;
        end
        return s;
    endfunction

    // A velocity whose sign is opposite to the last one is held at zero.
    function automatic t_vel flip_guard(input t_sign last, input t_vel v);
        logic signed [2:0] sum;
        t_sign             s;
        s   = sign_of(v);
        sum = {last[1], last} + {s[1], s};
        return (sum == 3'sd0) ? '0 : v;
    endfunction

endpackage

### hdl/bma_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/behavior_motor_arbiter.sv
// ----------------------------------------------------------------------------
// Behavior motor arbiter
// Stores behavior requests in a slot memory and, on each tick, picks the
// winning slot from the priority list and produces the motor command.
// ----------------------------------------------------------------------------
// Requests are written to slot memory in their transfer cycle, one per cycle if idle.
// A tick's result comes from the scan, which reads one priority entry per cycle
// (skipped on a halt), then the sign guard, the steer product and the clip.
// The next item is taken the cycle after the result register is loaded.
// Reset is synchronous and clears the slot valid bits, the sign state and the
// configuration registers at once; no clearing pass is needed.
module behavior_motor_arbiter
    import bma_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [IN_SLOT_W-1:0]        i_slot,
    input  logic signed [VEL_W-1:0]     i_left_request,
    input  logic signed [VEL_W-1:0]     i_right_request,
    input  logic                        i_wants_control,
    input  logic                        i_halt,
    input  logic                        i_battery_ok,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ENTRY_W-1:0]          o_winner,
    output logic signed [VEL_W-1:0]     o_motor_a,
    output logic signed [VEL_W-1:0]     o_motor_b
);

    t_state                  r_state;
    logic                    r_mode;
    logic [LIST_W-1:0]       r_prio;
    logic [GAIN_W-1:0]       r_gain;
    logic [LIMIT_W-1:0]      r_limit;
    logic [NUM_SLOTS-1:0]    r_valid;
    logic                    r_rd_vld;
    logic [CNT_W-1:0]        r_idx;
    logic                    r_pend;
    logic                    r_pend_ok;
    logic [ENTRY_W-1:0]      r_pend_slot;
    logic                    r_halt;
    logic                    r_bat;
    logic [ENTRY_W-1:0]      r_win;
    t_vel                    r_l;
    t_vel                    r_r;
    t_sign                   r_lsign;
    t_sign                   r_rsign;
    t_vel                    r_mag;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_out_valid;
    logic [ENTRY_W-1:0]      r_out_winner;
    t_vel                    r_out_a;
    t_vel                    r_out_b;

    logic                    in_xfer;
    logic                    out_xfer;
    logic                    req_we;
    logic [SLOT_W-1:0]       raddr;
    logic [REC_W-1:0]        rdata;
    logic [ENTRY_W-1:0]      entry;
    logic                    entry_ok;
    logic                    hit;
    logic                    out_write;
    t_vel                    rd_l;
    t_vel                    rd_r;
    t_vel                    n_l;
    t_vel                    n_r;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] abs_l;
    logic signed [DIFF_W-1:0] abs_r;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] steer;
    logic signed [PROD_W-1:0] lim;
    logic signed [PROD_W-1:0] clipped;
    t_sign                   mag_sign;
    t_vel                    n_out_a;
    t_vel                    n_out_b;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign req_we      = in_xfer && !i_operation && (int'(i_slot) < NUM_SLOTS);

    assign entry    = r_prio[r_idx[LIST_IDX_W-1:0]*ENTRY_W +: ENTRY_W];
    assign entry_ok = (int'(entry) < NUM_SLOTS);
    assign raddr    = (r_state == ST_SCAN) ? SLOT_W'(entry) : '0;

    bma_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (req_we),
        .i_waddr (SLOT_W'(i_slot)),
        .i_wdata ({i_wants_control, i_left_request, i_right_request}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Slots never written read as zero velocities that do not want control.
    assign rd_l = r_rd_vld ? t_vel'(rdata[2*VEL_W-1:VEL_W]) : '0;
    assign rd_r = r_rd_vld ? t_vel'(rdata[VEL_W-1:0]) : '0;
    assign hit  = r_pend && r_pend_ok && r_rd_vld && rdata[REC_W-1];

    assign n_l = flip_guard(r_lsign, r_l);
    assign n_r = flip_guard(r_rsign, r_r);

    assign diff   = {r_r[VEL_W-1], r_r} - {r_l[VEL_W-1], r_l};
    assign abs_l  = r_l[VEL_W-1] ? -{r_l[VEL_W-1], r_l} : {r_l[VEL_W-1], r_l};
    assign abs_r  = r_r[VEL_W-1] ? -{r_r[VEL_W-1], r_r} : {r_r[VEL_W-1], r_r};
    assign n_prod = diff * $signed({1'b0, r_gain});

    always_comb begin
        mag_sign = sign_of(r_mag);
        lim      = PROD_W'($signed({1'b0, r_limit}));
        if (mag_sign == 2'sd1) begin
            steer = r_prod;
        end else if (mag_sign == -2'sd1) begin
            steer = -r_prod;
        end else begin
            steer = '0;
        end
        if (steer > lim) begin
            clipped = lim;
        end else if (steer < -lim) begin
            clipped = -lim;
        end else begin
            clipped = steer;
        end
        if (!r_bat) begin
            n_out_a = '0;
            n_out_b = '0;
        end else if (r_mode) begin
            n_out_a = r_mag;
            n_out_b = VEL_W'(clipped);
        end else begin
            n_out_a = r_l;
            n_out_b = r_r;
        end
    end

    assign out_write = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_prio  <= '0;
            r_gain  <= GAIN_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DRIVE_MODE: r_mode  <= i_cfg_data[0];
                CFG_PRIORITY:   r_prio  <= i_cfg_data[LIST_W-1:0];
                CFG_GAIN:       r_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT:      r_limit <= i_cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_lsign     <= 2'sd0;
            r_rsign     <= 2'sd0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (req_we) begin
                r_valid[SLOT_W'(i_slot)] <= 1'b1;
            end
            if (out_write) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer && i_operation) begin
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= i_halt ? ST_FETCH : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Each cycle checks the entry read last cycle and reads the next.
                    if (hit) begin
                        r_state <= ST_GUARD;
                    end else if (r_idx == CNT_W'(LIST_LEN)) begin
                        r_state <= ST_FETCH;
                    end else begin
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                ST_FETCH: r_state <= ST_LOAD;
                ST_LOAD:  r_state <= ST_GUARD;
                ST_GUARD: begin
                    r_lsign <= sign_of(n_l);
                    r_rsign <= sign_of(n_r);
                    r_state <= ST_PROD;
                end
                ST_PROD: r_state <= ST_DONE;
                ST_DONE: begin
                    if (out_write) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[raddr];
        if (in_xfer) begin
            r_halt <= i_halt;
            r_bat  <= i_battery_ok;
        end
        if (r_state == ST_SCAN) begin
            r_pend_slot <= entry;
            r_pend_ok   <= entry_ok;
            if (hit) begin
                r_win <= r_pend_slot;
                r_l   <= rd_l;
                r_r   <= rd_r;
            end
        end
        if (r_state == ST_LOAD) begin
            r_win <= '0;
            r_l   <= rd_l;
            r_r   <= rd_r;
        end
        if (r_state == ST_GUARD) begin
            r_l <= n_l;
            r_r <= n_r;
        end
        if (r_state == ST_PROD) begin
            r_prod <= n_prod;
            r_mag  <= (abs_r > abs_l) ? r_r : r_l;
        end
        if (out_write) begin
            r_out_winner <= r_win;
            r_out_a      <= n_out_a;
            r_out_b      <= n_out_b;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_winner    = r_out_winner;
    assign o_motor_a   = r_out_a;
    assign o_motor_b   = r_out_b;

    // A halted tick always reports the default slot.
    a_halt_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_write && r_halt) |=> (o_winner == '0))
        else $error("halted tick did not report slot 0");

    // A low battery gives a zero command on both motors.
    a_battery_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_write && !r_bat) |=> (o_motor_a == '0 && o_motor_b == '0))
        else $error("low battery command is not zero");

    // The stored last signs are always -1, 0 or +1.
    a_sign_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lsign != -2'sd2) && (r_rsign != -2'sd2))
        else $error("last sign state out of range");

    // A scan hit only comes from a slot that has been written.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && hit) |-> r_valid[SLOT_W'(r_pend_slot)])
        else $error("scan hit on an unwritten slot");

endmodule
